@@ rtl/ipt_pkg.sv @@
// ----------------------------------------------------------------------------
// IP prefix table package
// Shared widths, request codes and the entry, query and match structs.
// ----------------------------------------------------------------------------
package ipt_pkg;

   localparam int TABLE_ENTRIES_DEF = 256;

   localparam int ADDR_W    = 32;
   localparam int LEN_W     = 6;
   localparam int REQ_W     = 2;
   localparam int REMOVED_W = 9;
   localparam int OCTET_W   = 8;

   localparam logic [REQ_W-1:0]     REQ_INSERT  = 2'd0;
   localparam logic [REQ_W-1:0]     REQ_DELETE  = 2'd1;
   localparam logic [REQ_W-1:0]     REQ_SEARCH  = 2'd2;
   localparam logic [LEN_W-1:0]     MAX_LEN     = 6'd32;
   localparam logic [REMOVED_W-1:0] REMOVED_MAX = 9'd511;
   localparam logic [ADDR_W-1:0]    ALL_ONES    = 32'hFFFF_FFFF;

   typedef struct packed {
      logic              valid;
      logic [ADDR_W-1:0] addr;
      logic [LEN_W-1:0]  len;
   } entry_type;

   typedef struct packed {
      logic [ADDR_W-1:0] addr;
      logic [LEN_W-1:0]  len;
   } query_type;

   typedef struct packed {
      logic free;
      logic del_hit;
      logic srch_hit;
   } match_type;

endpackage

@@ rtl/ipt_if.sv @@
// ----------------------------------------------------------------------------
// IP prefix table channels
// Valid/ready channels for request beats and response beats.
// ----------------------------------------------------------------------------
interface ipt_req_if;
   import ipt_pkg::*;

   logic              valid;
   logic              ready;
   logic [REQ_W-1:0]  req_type;
   logic [ADDR_W-1:0] address;
   logic [LEN_W-1:0]  prefix_len;

   modport source (output valid, output req_type, output address, output prefix_len,
                   input ready);
   modport sink   (input valid, input req_type, input address, input prefix_len,
                   output ready);
endinterface

interface ipt_rsp_if;
   import ipt_pkg::*;

   logic                 valid;
   logic                 ready;
   logic                 status;
   logic                 hit;
   logic [REMOVED_W-1:0] removed;

   modport source (output valid, output status, output hit, output removed,
                   input ready);
   modport sink   (input valid, input status, input hit, input removed,
                   output ready);
endinterface

@@ rtl/ipt_store.sv @@
// ----------------------------------------------------------------------------
// IP prefix table store
// Entry memory with one write port and one registered read port.
// ----------------------------------------------------------------------------
module ipt_store #(
   parameter int ENTRIES = ipt_pkg::TABLE_ENTRIES_DEF
) (
   input  logic                       clock,
   input  logic                       rd_en,
   input  logic [$clog2(ENTRIES)-1:0] rd_idx,
   output ipt_pkg::entry_type         rd_data,
   input  logic                       wr_en,
   input  logic                       wr_entry,
   input  logic [$clog2(ENTRIES)-1:0] wr_idx,
   input  ipt_pkg::entry_type         wr_data
);
   import ipt_pkg::*;

   logic              valid_mem [ENTRIES];
   logic [ADDR_W-1:0] addr_mem  [ENTRIES];
   logic [LEN_W-1:0]  len_mem   [ENTRIES];

   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         valid_mem[wr_idx] <= wr_data.valid;
      end
      if (wr_en && wr_entry) begin
         addr_mem[wr_idx] <= wr_data.addr;
         len_mem[wr_idx]  <= wr_data.len;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff.valid <= valid_mem[rd_idx];
         rd_data_ff.addr  <= addr_mem[rd_idx];
         rd_data_ff.len   <= len_mem[rd_idx];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/ipt_match.sv @@
// ----------------------------------------------------------------------------
// IP prefix table compare unit
// Checks one stored entry against the request: free slot, exact delete match
// and first-octet prefix search match.
// ----------------------------------------------------------------------------
module ipt_match (
   input  ipt_pkg::entry_type entry,
   input  ipt_pkg::query_type query,
   output ipt_pkg::match_type result
);
   import ipt_pkg::*;

   logic [ADDR_W-1:0] mask;
   logic              octet_eq;

   assign mask     = ~(ALL_ONES >> entry.len);
   assign octet_eq = entry.addr[ADDR_W-1 -: OCTET_W] == query.addr[ADDR_W-1 -: OCTET_W];

   always_comb begin
      result.free     = !entry.valid;
      result.del_hit  = entry.valid && (entry.addr == query.addr) && (entry.len == query.len);
      result.srch_hit = entry.valid && (entry.len <= MAX_LEN) && octet_eq &&
                        ((entry.addr & mask) == (query.addr & mask));
   end

endmodule

@@ rtl/ip_prefix_table_match.sv @@
// ----------------------------------------------------------------------------
// IP prefix table match
// Insert stops at the first free slot and search at the first hit; delete
// scans every entry and an unused code goes straight to the response.
// Throughput: one request at a time; one entry per cycle through the single
// memory read port and compare unit; a new request is taken after the response.
// Reset: a clearing pass marks every slot free; no request is taken
// meanwhile.
// ----------------------------------------------------------------------------
module ip_prefix_table_match #(
   parameter int TABLE_ENTRIES = ipt_pkg::TABLE_ENTRIES_DEF
) (
   input logic       clock,
   input logic       reset,
   ipt_req_if.sink   req_if,
   ipt_rsp_if.source rsp_if
);
   import ipt_pkg::*;

   localparam int              IDX_W    = $clog2(TABLE_ENTRIES);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

   typedef enum logic [3:0] {
      ST_CLEAR = 4'b0001,
      ST_IDLE  = 4'b0010,
      ST_SCAN  = 4'b0100,
      ST_RESP  = 4'b1000
   } state_type;

   state_type            state_ff, state_in;
   logic [IDX_W-1:0]     scan_idx_ff, scan_idx_in;
   logic                 issue_done_ff, issue_done_in;
   logic                 chk_vld_ff, chk_vld_in;
   logic [IDX_W-1:0]     chk_idx_ff, chk_idx_in;
   logic [REQ_W-1:0]     req_type_ff, req_type_in;
   query_type            query_ff, query_in;
   logic                 status_ff, status_in;
   logic                 hit_ff, hit_in;
   logic [REMOVED_W-1:0] removed_ff, removed_in;

   logic             rd_en;
   entry_type        rd_data;
   logic             wr_en;
   logic             wr_entry;
   logic [IDX_W-1:0] wr_idx;
   entry_type        wr_data;
   match_type        match;

   ipt_store #(.ENTRIES(TABLE_ENTRIES)) u_store (
      .clock    (clock),
      .rd_en    (rd_en),
      .rd_idx   (scan_idx_ff),
      .rd_data  (rd_data),
      .wr_en    (wr_en),
      .wr_entry (wr_entry),
      .wr_idx   (wr_idx),
      .wr_data  (wr_data)
   );

   ipt_match u_match (
      .entry  (rd_data),
      .query  (query_ff),
      .result (match)
   );

   assign req_if.ready   = state_ff == ST_IDLE;
   assign rsp_if.valid   = state_ff == ST_RESP;
   assign rsp_if.status  = status_ff;
   assign rsp_if.hit     = hit_ff;
   assign rsp_if.removed = removed_ff;

   always_comb begin
      logic finish;
      logic last;
      finish        = 1'b0;
      last          = chk_idx_ff == LAST_IDX;
      state_in      = state_ff;
      scan_idx_in   = scan_idx_ff;
      issue_done_in = issue_done_ff;
      chk_vld_in    = 1'b0;
      chk_idx_in    = chk_idx_ff;
      req_type_in   = req_type_ff;
      query_in      = query_ff;
      status_in     = status_ff;
      hit_in        = hit_ff;
      removed_in    = removed_ff;
      rd_en         = 1'b0;
      wr_en         = 1'b0;
      wr_entry      = 1'b0;
      wr_idx        = chk_idx_ff;
      wr_data.valid = 1'b0;
      wr_data.addr  = query_ff.addr;
      wr_data.len   = query_ff.len;

      unique case (state_ff)
         ST_CLEAR: begin
            wr_en       = 1'b1;
            wr_idx      = scan_idx_ff;
            scan_idx_in = scan_idx_ff + 1'b1;
            if (scan_idx_ff == LAST_IDX) begin
               scan_idx_in = '0;
               state_in    = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_if.valid) begin
               req_type_in    = req_if.req_type;
               query_in.addr  = req_if.address;
               query_in.len   = req_if.prefix_len;
               status_in      = 1'b0;
               hit_in         = 1'b0;
               removed_in     = '0;
               scan_idx_in    = '0;
               issue_done_in  = 1'b0;
               if (req_if.req_type == REQ_INSERT || req_if.req_type == REQ_DELETE ||
                   req_if.req_type == REQ_SEARCH) begin
                  state_in = ST_SCAN;
               end else begin
                  state_in = ST_RESP;
               end
            end
         end
         ST_SCAN: begin
            if (chk_vld_ff) begin
               if (req_type_ff == REQ_INSERT) begin
                  if (match.free) begin
                     wr_en         = 1'b1;
                     wr_entry      = 1'b1;
                     wr_data.valid = 1'b1;
                     finish        = 1'b1;
                  end else if (last) begin
                     status_in = 1'b1;
                     finish    = 1'b1;
                  end
               end else if (req_type_ff == REQ_DELETE) begin
                  if (match.del_hit) begin
                     wr_en = 1'b1;
                     if (removed_ff != REMOVED_MAX) begin
                        removed_in = removed_ff + 1'b1;
                     end
                  end
                  finish = last;
               end else begin
                  if (match.srch_hit) begin
                     hit_in = 1'b1;
                     finish = 1'b1;
                  end else begin
                     finish = last;
                  end
               end
            end
            if (finish) begin
               state_in = ST_RESP;
            end else if (!issue_done_ff) begin
               rd_en       = 1'b1;
               chk_vld_in  = 1'b1;
               chk_idx_in  = scan_idx_ff;
               scan_idx_in = scan_idx_ff + 1'b1;
               if (scan_idx_ff == LAST_IDX) begin
                  issue_done_in = 1'b1;
               end
            end
         end
         ST_RESP: begin
            if (rsp_if.ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         scan_idx_ff   <= '0;
         issue_done_ff <= 1'b0;
         chk_vld_ff    <= 1'b0;
      end else begin
         state_ff      <= state_in;
         scan_idx_ff   <= scan_idx_in;
         issue_done_ff <= issue_done_in;
         chk_vld_ff    <= chk_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      chk_idx_ff  <= chk_idx_in;
      req_type_ff <= req_type_in;
      query_ff    <= query_in;
      status_ff   <= status_in;
      hit_ff      <= hit_in;
      removed_ff  <= removed_in;
   end

   assert property (@(posedge clock) disable iff (reset)
      !(req_if.ready && rsp_if.valid))
      else $error("request and response handshakes open together");

   assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (state_ff == ST_SCAN || state_ff == ST_CLEAR))
      else $error("store write outside scan or clear");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && rsp_if.ready) |=> state_ff == ST_IDLE)
      else $error("no return to idle after response beat");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && removed_ff != '0) |-> req_type_ff == REQ_DELETE)
      else $error("removed count on a request other than delete");

endmodule

@@ bench/ipt_reply_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IP prefix table reply checker
// Watches request and response beats, keeps its own copy of the prefix
// table, predicts each reply in request order and compares it field by field.
// ----------------------------------------------------------------------------
module ipt_reply_checker #(
   parameter int TABLE_ENTRIES = ipt_pkg::TABLE_ENTRIES_DEF
) (
   input  logic clock,
   input  logic reset,
   ipt_req_if   req_mon,
   ipt_rsp_if   rsp_mon,
   output int   error_count,
   output int   outstanding
);
   import ipt_pkg::*;

   typedef struct packed {
      logic                 status;
      logic                 hit;
      logic [REMOVED_W-1:0] removed;
   } reply_type;

   logic              slot_valid [TABLE_ENTRIES];
   logic [ADDR_W-1:0] slot_addr  [TABLE_ENTRIES];
   logic [LEN_W-1:0]  slot_len   [TABLE_ENTRIES];

   reply_type reply_q[$];
   int        fail_tally;

   function automatic logic [ADDR_W-1:0] prefix_mask(input logic [LEN_W-1:0] len);
      if (len == 0)
         return '0;
      return ALL_ONES << (ADDR_W - int'(len));
   endfunction

   function automatic reply_type predict_table_reply(input logic [REQ_W-1:0] kind,
                                                     input logic [ADDR_W-1:0] addr,
                                                     input logic [LEN_W-1:0] len);
      reply_type reply;
      logic      placed;
      logic [ADDR_W-1:0] mask;
      reply  = '0;
      placed = 1'b0;
      if (kind == REQ_INSERT) begin
         for (int k = 0; k < TABLE_ENTRIES; k++) begin
            if (!placed && !slot_valid[k]) begin
               slot_valid[k] = 1'b1;
               slot_addr[k]  = addr;
               slot_len[k]   = len;
               placed        = 1'b1;
            end
         end
         reply.status = !placed;
      end else if (kind == REQ_DELETE) begin
         for (int k = 0; k < TABLE_ENTRIES; k++) begin
            if (slot_valid[k] && slot_addr[k] == addr && slot_len[k] == len) begin
               slot_valid[k] = 1'b0;
               if (reply.removed < REMOVED_MAX)
                  reply.removed = reply.removed + 1'b1;
            end
         end
      end else if (kind == REQ_SEARCH) begin
         for (int k = 0; k < TABLE_ENTRIES; k++) begin
            if (slot_valid[k] && slot_len[k] <= MAX_LEN &&
                slot_addr[k][ADDR_W-1 -: OCTET_W] == addr[ADDR_W-1 -: OCTET_W]) begin
               mask = prefix_mask(slot_len[k]);
               if ((slot_addr[k] & mask) == (addr & mask))
                  reply.hit = 1'b1;
            end
         end
      end
      return reply;
   endfunction

   always @(posedge clock) begin
      reply_type want;
      if (reset) begin
         for (int k = 0; k < TABLE_ENTRIES; k++)
            slot_valid[k] = 1'b0;
         reply_q.delete();
         fail_tally = 0;
      end else begin
         if (req_mon.valid && req_mon.ready)
            reply_q.push_back(predict_table_reply(req_mon.req_type, req_mon.address,
                                                  req_mon.prefix_len));
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (reply_q.size() == 0) begin
               $error("response beat with no request pending");
               fail_tally++;
            end else begin
               want = reply_q.pop_front();
               if (rsp_mon.status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_mon.status);
                  fail_tally++;
               end
               if (rsp_mon.hit !== want.hit) begin
                  $error("hit: expected %0d, got %0d", want.hit, rsp_mon.hit);
                  fail_tally++;
               end
               if (rsp_mon.removed !== want.removed) begin
                  $error("removed: expected %0d, got %0d", want.removed, rsp_mon.removed);
                  fail_tally++;
               end
            end
         end
      end
      error_count <= fail_tally;
      outstanding <= reply_q.size();
   end

endmodule

@@ bench/ip_prefix_table_match_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IP prefix table match testbench
// Drives insert, delete, search and unused-code requests in random bursts against the
// prefix table, stalls the response side, and lets the checker judge replies.
// ----------------------------------------------------------------------------
module ip_prefix_table_match_tb;
   import ipt_pkg::*;

   localparam int                TABLE_ENTRIES = TABLE_ENTRIES_DEF;
   localparam logic [REQ_W-1:0]  REQ_UNUSED    = 2'd3;
   localparam int                RANDOM_ITEMS  = 2000;
   localparam int                PHASE_ITEMS   = 400;
   localparam int                POOL_MAX      = 400;
   localparam int                SETTLE_CYCLES = TABLE_ENTRIES + 16;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   error_count;
   int   outstanding;

   ipt_req_if req_if ();
   ipt_rsp_if rsp_if ();

   query_type prefix_pool[$];

   logic [15:0] stall_bits;
   logic [9:0]  stall_count;
   logic [1:0]  stall_mode;

   ip_prefix_table_match #(.TABLE_ENTRIES(TABLE_ENTRIES)) dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   ipt_reply_checker #(.TABLE_ENTRIES(TABLE_ENTRIES)) checker_i (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_if),
      .rsp_mon     (rsp_if),
      .error_count (error_count),
      .outstanding (outstanding)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (reset) begin
         stall_bits    <= '1;
         stall_count   <= '0;
         stall_mode    <= '0;
         rsp_if.ready  <= 1'b0;
      end else begin
         stall_count <= stall_count + 1'b1;
         if (stall_count[3:0] == 0)
            stall_bits <= 16'($urandom);
         if (stall_count == 0)
            stall_mode <= 2'($urandom_range(2));
         case (stall_mode)
            2'd0: rsp_if.ready <= 1'b1;
            2'd1: rsp_if.ready <= stall_bits[stall_count[3:0]];
            default: rsp_if.ready <= ($urandom_range(3) != 0);
         endcase
      end
   end

   task automatic send_request(input logic [REQ_W-1:0] kind, input logic [ADDR_W-1:0] addr,
                               input logic [LEN_W-1:0] len);
      req_if.valid      <= 1'b1;
      req_if.req_type   <= kind;
      req_if.address    <= addr;
      req_if.prefix_len <= len;
      do @(posedge clock); while (!req_if.ready);
   endtask

   task automatic hold_idle(input int cycles);
      req_if.valid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   task automatic wait_drained();
      req_if.valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   function automatic logic [OCTET_W-1:0] pick_octet();
      case ($urandom_range(4))
         0: return 8'h0A;
         1: return 8'hC0;
         2: return 8'h00;
         3: return 8'hFF;
         default: return 8'($urandom);
      endcase
   endfunction

   function automatic logic [LEN_W-1:0] pick_len();
      if ($urandom_range(15) == 0)
         return 6'($urandom_range(63, 33));
      return 6'($urandom_range(32));
   endfunction

   task automatic send_random(input int item);
      logic [REQ_W-1:0]  kind;
      logic [ADDR_W-1:0] addr;
      logic [ADDR_W-1:0] mask;
      logic [LEN_W-1:0]  len;
      int                roll;
      int                pick;
      bit                filling;
      filling = ((item / PHASE_ITEMS) % 2) == 0;
      roll    = $urandom_range(99);
      addr    = {pick_octet(), 24'($urandom)};
      len     = pick_len();
      if (roll < (filling ? 82 : 15)) begin
         kind = REQ_INSERT;
         if (prefix_pool.size() != 0 && $urandom_range(3) == 0) begin
            pick = $urandom_range(prefix_pool.size() - 1);
            addr = prefix_pool[pick].addr;
            len  = prefix_pool[pick].len;
         end
         if (prefix_pool.size() < POOL_MAX)
            prefix_pool.push_back('{addr: addr, len: len});
      end else if (roll < (filling ? 92 : 45)) begin
         kind = REQ_SEARCH;
         if (prefix_pool.size() != 0 && $urandom_range(3) != 0) begin
            pick = $urandom_range(prefix_pool.size() - 1);
            mask = (prefix_pool[pick].len == 0 || prefix_pool[pick].len > MAX_LEN) ?
                   ALL_ONES >> OCTET_W : ~(ALL_ONES << (ADDR_W - prefix_pool[pick].len));
            if ($urandom_range(1) == 0)
               mask = mask >> $urandom_range(ADDR_W - 1);
            addr = prefix_pool[pick].addr ^ ($urandom & mask);
         end
      end else if (roll < (filling ? 97 : 95)) begin
         kind = REQ_DELETE;
         if (prefix_pool.size() != 0 && $urandom_range(4) != 0) begin
            pick = $urandom_range(prefix_pool.size() - 1);
            addr = prefix_pool[pick].addr;
            len  = prefix_pool[pick].len;
            prefix_pool.delete(pick);
         end
      end else begin
         kind = REQ_UNUSED;
         addr = $urandom;
         len  = 6'($urandom);
      end
      send_request(kind, addr, len);
   endtask

   initial begin
      int burst_left;
      req_if.valid      <= 1'b0;
      req_if.req_type   <= REQ_INSERT;
      req_if.address    <= '0;
      req_if.prefix_len <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_request(REQ_SEARCH, 32'hFFFF_FFFF, 6'd0);
      send_request(REQ_INSERT, 32'h0A00_0000, 6'd8);
      send_request(REQ_SEARCH, 32'h0A12_3456, 6'd63);
      send_request(REQ_SEARCH, 32'h0B00_0000, 6'd0);
      send_request(REQ_INSERT, 32'hC0A8_0100, 6'd24);
      send_request(REQ_SEARCH, 32'hC0A8_01FF, 6'd0);
      send_request(REQ_SEARCH, 32'hC0A8_0201, 6'd0);
      send_request(REQ_INSERT, 32'hFFFF_FFFF, 6'd32);
      send_request(REQ_SEARCH, 32'hFFFF_FFFF, 6'd0);
      send_request(REQ_SEARCH, 32'hFFFF_FFFE, 6'd0);
      send_request(REQ_INSERT, 32'h8000_0000, 6'd0);
      send_request(REQ_SEARCH, 32'h80FF_FFFF, 6'd0);
      send_request(REQ_SEARCH, 32'h7F00_0000, 6'd0);
      send_request(REQ_INSERT, 32'h0102_0304, 6'd40);
      send_request(REQ_SEARCH, 32'h0102_0304, 6'd40);
      send_request(REQ_INSERT, 32'h0A00_0000, 6'd8);
      send_request(REQ_DELETE, 32'h0A00_0000, 6'd8);
      send_request(REQ_DELETE, 32'h0A00_0000, 6'd16);
      send_request(REQ_DELETE, 32'h0102_0304, 6'd40);
      send_request(REQ_UNUSED, 32'hFFFF_FFFF, 6'd63);
      send_request(REQ_SEARCH, 32'h0A12_3456, 6'd0);
      send_request(REQ_INSERT, 32'h0000_0000, 6'd63);
      send_request(REQ_DELETE, 32'h0000_0000, 6'd63);
      wait_drained();

      burst_left = $urandom_range(1, 40);
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         send_random(i);
         if (i == RANDOM_ITEMS / 2) begin
            wait_drained();
         end else if (--burst_left == 0) begin
            hold_idle($urandom_range(1, 8));
            burst_left = $urandom_range(1, 40);
         end
      end

      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (outstanding != 0)
         $error("%0d expected responses never arrived", outstanding);
      if (error_count == 0 && outstanding == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

   initial begin
      #6ms;
      $display("Some tests failed");
      $finish;
   end

endmodule
